/* hw/rtl/hdr_pixel_tone_mapper_defines.svh */
// Assertion macros shared by the tone mapper RTL.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef HDR_PIXEL_TONE_MAPPER_DEFINES_SVH
`define HDR_PIXEL_TONE_MAPPER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hpt_pkg.sv */
// Package for the HDR pixel tone mapper: widths, constants, register codes and types.
// No dependencies; imported by hpt_curve and hdr_pixel_tone_mapper.
package hpt_pkg;

  localparam int FRAC_W      = 16;                 // channel fraction bits
  localparam int CH_W        = 24;                 // unsigned channel width
  localparam int IN_W        = 25;                 // signed input channel width
  localparam int IN_TDATA_W  = 80;                 // 3 x 25 bits padded to bytes
  localparam int OUT_TDATA_W = 72;                 // 3 x 24 bits
  localparam int GAIN_FRAC   = 12;
  localparam int ADDR_W      = 5;

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};
  localparam logic [17:0] P_MIN = 18'(((5 << FRAC_W) + 50) / 100);
  localparam logic [29:0] BASE  = 30'(10000 << FRAC_W);

  // Restoring dividers produce one quotient bit per stage.
  localparam int DIV_STEPS = CH_W;
  localparam int CURVE_LAT = DIV_STEPS + 6;
  localparam int PIPE_DEPTH = 4 + CURVE_LAT + 1 + DIV_STEPS + 2;

  // Curve divider widths.
  localparam int CREM_W = 58;
  localparam int CDEN_W = 41;
  localparam int CSH_W  = CDEN_W + DIV_STEPS - 1;
  localparam int TREM_W = 47;
  localparam int TDEN_W = 27;
  localparam int TSH_W  = TDEN_W + DIV_STEPS - 1;

  // floor(v/100) = (v * RECIP_100) >> RECIP_SH for all v below 2^31.
  localparam logic [31:0] RECIP_100 = 32'd2748779070;
  localparam int RECIP_SH = 38;

  typedef enum logic [2:0] {
    REG_GAIN  = 3'd0,
    REG_PIVOT = 3'd1,
    REG_COMP  = 3'd2,
    REG_SHLD  = 3'd3,
    REG_SATP  = 3'd4,
    REG_WR    = 3'd5,
    REG_WG    = 3'd6,
    REG_WB    = 3'd7
  } reg_idx_t;

  // Curve constants derived from the configuration registers.
  typedef struct packed {
    logic [17:0] p;    // effective pivot
    logic [15:0] n;    // compression * (20 + 4 * shoulder)
    logic [33:0] a;    // BASE + n * p
    logic [27:0] pe;   // p * (600 - 4 * shoulder), shoulder end times 100
    logic [26:0] pd;   // p * (500 - 4 * shoulder)
    logic        off;  // compression is zero
  } cfg_derived_t;

  function automatic logic [6:0] pct(input logic [6:0] v);
    pct = (v > 7'd100) ? 7'd100 : v;
  endfunction

endpackage

/* hw/rtl/hpt_curve.sv */
// Pipelined shoulder-blended compression curve for one unsigned Q8.16 value.
// Depends on hpt_pkg; every register advances only when ce is high.
module hpt_curve (
  input  logic                 clk,
  input  logic                 ce,
  input  hpt_pkg::cfg_derived_t cd,
  input  logic [hpt_pkg::CH_W-1:0] x,
  output logic [hpt_pkg::CH_W-1:0] y
);
  import hpt_pkg::*;

  logic [CH_W-1:0] x1_r;
  logic [39:0]     nx1_r;
  logic [40:0]     pl1_r;
  logic [40:0]     ph1_r;
  logic [30:0]     tn1_r;
  logic            byp1_r;
  logic            wf1_r;

  logic [CREM_W-1:0] crem_r [DIV_STEPS+1];
  logic [CDEN_W-1:0] cden_r [DIV_STEPS+1];
  logic [CH_W-1:0]   cq_r   [DIV_STEPS+1];
  logic [TREM_W-1:0] trem_r [DIV_STEPS+1];
  logic [TDEN_W-1:0] tden_r [DIV_STEPS+1];
  logic [CH_W-1:0]   tq_r   [DIV_STEPS+1];
  logic [CH_W-1:0]   xd_r   [DIV_STEPS+1];
  logic              bypd_r [DIV_STEPS+1];
  logic              wfd_r  [DIV_STEPS+1];

  logic [CSH_W-1:0] csh [DIV_STEPS];
  logic [TSH_W-1:0] tsh [DIV_STEPS];

  logic [33:0]     tt_r;
  logic [17:0]     t3_r;
  logic [CH_W-1:0] diff_r;
  logic [CH_W-1:0] diff2_r;
  logic [16:0]     w_r;
  logic [40:0]     prod_r;
  logic [CH_W-1:0] xe1_r, xe2_r, xe3_r;
  logic            bype1_r, bype2_r, bype3_r;
  logic            wfe1_r;
  logic [CH_W-1:0] y_r;
  logic [16:0]     tval;
  logic [51:0]     wprod;

  // Shifted divisors for each quotient bit.
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      csh[k] = CSH_W'(cden_r[k]) << (DIV_STEPS - 1 - k);
      tsh[k] = TSH_W'(tden_r[k]) << (DIV_STEPS - 1 - k);
    end
  end

  // Front end: products and decisions that depend only on x.
  always_ff @(posedge clk) begin
    if (ce) begin
      x1_r   <= x;
      nx1_r  <= 40'(cd.n) * 40'(x);
      pl1_r  <= 41'(x) * 41'(cd.a[16:0]);
      ph1_r  <= 41'(x) * 41'(cd.a[33:17]);
      tn1_r  <= 31'(CH_W'(x - CH_W'(cd.p))) * 31'(100);
      byp1_r <= (x == '0) || cd.off || (x <= CH_W'(cd.p));
      wf1_r  <= (31'(x) * 31'(100)) >= 31'(cd.pe);
    end
  end

  // Divider load and restoring steps for comp and the blend position t.
  always_ff @(posedge clk) begin
    if (ce) begin
      crem_r[0] <= (CREM_W'(ph1_r) << 17) + CREM_W'(pl1_r);
      cden_r[0] <= CDEN_W'(BASE) + CDEN_W'(nx1_r);
      cq_r[0]   <= '0;
      trem_r[0] <= TREM_W'(tn1_r) << 16;
      tden_r[0] <= cd.pd;
      tq_r[0]   <= '0;
      xd_r[0]   <= x1_r;
      bypd_r[0] <= byp1_r;
      wfd_r[0]  <= wf1_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (CSH_W'(crem_r[k]) >= csh[k]) begin
          crem_r[k+1] <= CREM_W'(CSH_W'(crem_r[k]) - csh[k]);
          cq_r[k+1]   <= cq_r[k] | (CH_W'(1) << (DIV_STEPS - 1 - k));
        end else begin
          crem_r[k+1] <= crem_r[k];
          cq_r[k+1]   <= cq_r[k];
        end
        if (TSH_W'(trem_r[k]) >= tsh[k]) begin
          trem_r[k+1] <= TREM_W'(TSH_W'(trem_r[k]) - tsh[k]);
          tq_r[k+1]   <= tq_r[k] | (CH_W'(1) << (DIV_STEPS - 1 - k));
        end else begin
          trem_r[k+1] <= trem_r[k];
          tq_r[k+1]   <= tq_r[k];
        end
        cden_r[k+1] <= cden_r[k];
        tden_r[k+1] <= tden_r[k];
        xd_r[k+1]   <= xd_r[k];
        bypd_r[k+1] <= bypd_r[k];
        wfd_r[k+1]  <= wfd_r[k];
      end
    end
  end

  // t stays below one in Q0.16 whenever the smoothstep weight is used.
  assign tval  = tq_r[DIV_STEPS][16:0];
  assign wprod = 52'(tt_r) * 52'(t3_r);

  // Smoothstep weight and the blend between x and comp.
  always_ff @(posedge clk) begin
    if (ce) begin
      tt_r    <= 34'(tval) * 34'(tval);
      t3_r    <= 18'd196608 - {tval, 1'b0};
      diff_r  <= xd_r[DIV_STEPS] - cq_r[DIV_STEPS];
      xe1_r   <= xd_r[DIV_STEPS];
      bype1_r <= bypd_r[DIV_STEPS];
      wfe1_r  <= wfd_r[DIV_STEPS];

      w_r     <= wfe1_r ? 17'h10000 : wprod[48:32];
      diff2_r <= diff_r;
      xe2_r   <= xe1_r;
      bype2_r <= bype1_r;

      prod_r  <= 41'(diff2_r) * 41'(w_r);
      xe3_r   <= xe2_r;
      bype3_r <= bype2_r;

      y_r     <= bype3_r ? xe3_r : xe3_r - prod_r[39:16];
    end
  end

  assign y = y_r;

endmodule

/* hw/rtl/hdr_pixel_tone_mapper.sv */
// Top level of the HDR pixel tone mapper: stream ports, APB registers, pipeline.
// Depends on hpt_pkg, hpt_curve and hdr_pixel_tone_mapper_defines.svh.
//
//   Channel  Direction  Handshake                     Payload
//   in_      slave      in_tvalid / in_tready         red, green, blue (signed Q8.16)
//   out_     master     out_tvalid / out_tready       red, green, blue (unsigned Q8.16)
//   cfg_     APB slave  psel, penable, pwrite, pready eight 32-bit registers at 4*i
//
// One pixel transaction is accepted per clock while the pipeline is not stalled. Most
// of the latency comes from the two 24-step restoring dividers in series: the curve
// divider and the luminance-scale divider.
// rst_n is synchronous; it clears the valid bits and resets the configuration registers.
// When the output register holds a transaction that is not taken, the whole pipeline
// holds, and in_tready is low in that cycle.
`include "hdr_pixel_tone_mapper_defines.svh"

module hdr_pixel_tone_mapper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fields from bit 0: red_in[24:0], green_in[24:0], blue_in[24:0], zero padding
  input  logic [hpt_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fields from bit 0: red_out[23:0], green_out[23:0], blue_out[23:0]
  output logic [hpt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hpt_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import hpt_pkg::*;

  // Configuration registers.
  logic [15:0] gain_r;
  logic [17:0] pivot_r;
  logic [6:0]  comp_r;
  logic [6:0]  shld_r;
  logic [6:0]  satp_r;
  logic [15:0] wr_r, wg_r, wb_r;

  cfg_derived_t cd1_nxt, cd1_r, cd_nxt, cd_r;
  logic [6:0]   c_pct, s_pct, q_pct;
  logic [8:0]   s4;
  reg_idx_t     cfg_idx;

  logic                   ce;
  logic [PIPE_DEPTH-1:0]  vld_r;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [CH_W-1:0] cin [3];
  logic [15:0]     wsel [3];
  logic [39:0]     gp_r [3];
  logic [CH_W-1:0] ch2_r [3];
  logic [39:0]     wp_r [3];
  logic [CH_W-1:0] ch3_r [3];
  logic [CH_W-1:0] ch4_r [3];
  logic [CH_W-1:0] lum4_r;
  logic [41:0]     wsum;

  logic [CH_W-1:0] mlum;
  logic [CH_W-1:0] cv [3];
  logic [CH_W-1:0] chdl_r [CURVE_LAT][3];
  logic [CH_W-1:0] lumdl_r [CURVE_LAT];

  logic [47:0]     lrem_r [DIV_STEPS+1][3];
  logic [CH_W-1:0] lq_r   [DIV_STEPS+1][3];
  logic [CH_W-1:0] cvd_r  [DIV_STEPS+1][3];
  logic [CH_W-1:0] lden_r [DIV_STEPS+1];
  logic            lnz_r  [DIV_STEPS+1];
  logic [47:0]     lsh    [DIV_STEPS];
  logic [CH_W-1:0] ls     [3];

  logic [30:0] mix_r [3];
  logic [62:0] rp_r  [3];

  // ---------------------------------------------------------------------------
  // APB register file. Writes land on the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= 16'd4096;
      pivot_r <= 18'd11796;
      comp_r  <= '0;
      shld_r  <= '0;
      satp_r  <= '0;
      wr_r    <= 16'd13933;
      wg_r    <= 16'd46871;
      wb_r    <= 16'd4732;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_idx)
        REG_GAIN:  gain_r  <= cfg_pwdata[15:0];
        REG_PIVOT: pivot_r <= cfg_pwdata[17:0];
        REG_COMP:  comp_r  <= cfg_pwdata[6:0];
        REG_SHLD:  shld_r  <= cfg_pwdata[6:0];
        REG_SATP:  satp_r  <= cfg_pwdata[6:0];
        REG_WR:    wr_r    <= cfg_pwdata[15:0];
        REG_WG:    wg_r    <= cfg_pwdata[15:0];
        REG_WB:    wb_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN:  cfg_prdata = 32'(gain_r);
      REG_PIVOT: cfg_prdata = 32'(pivot_r);
      REG_COMP:  cfg_prdata = 32'(comp_r);
      REG_SHLD:  cfg_prdata = 32'(shld_r);
      REG_SATP:  cfg_prdata = 32'(satp_r);
      REG_WR:    cfg_prdata = 32'(wr_r);
      REG_WG:    cfg_prdata = 32'(wg_r);
      REG_WB:    cfg_prdata = 32'(wb_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Curve constants. They follow the registers through cd1_r and then cd_r, long
  // before a pixel accepted after a register write reaches the curve units.
  // ---------------------------------------------------------------------------
  assign c_pct = pct(comp_r);
  assign s_pct = pct(shld_r);
  assign q_pct = pct(satp_r);
  assign s4    = {s_pct, 2'b00};

  always_comb begin
    cd1_nxt     = '0;
    cd1_nxt.p   = (pivot_r < P_MIN) ? P_MIN : pivot_r;
    cd1_nxt.n   = 16'(c_pct) * (16'd20 + 16'(s4));
    cd1_nxt.pe  = 28'(cd1_nxt.p) * (28'd600 - 28'(s4));
    cd1_nxt.pd  = 27'(cd1_nxt.p) * (27'd500 - 27'(s4));
    cd1_nxt.off = (c_pct == '0);
  end

  always_comb begin
    cd_nxt   = cd1_r;
    cd_nxt.a = 34'(BASE) + 34'(cd1_r.n) * 34'(cd1_r.p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd1_r    <= '{p: 18'd11796, n: '0, a: '0, pe: 28'd7077600, pd: 27'd5898000,
                    off: 1'b1};
      cd_r     <= '{p: 18'd11796, n: '0, a: 34'(BASE), pe: 28'd7077600,
                    pd: 27'd5898000, off: 1'b1};
    end else begin
      cd1_r    <= cd1_nxt;
      cd_r     <= cd_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage moves together whenever the output register is
  // empty or being drained. Valid bits ride alongside the data.
  // ---------------------------------------------------------------------------
  assign ce        = !out_tvalid_r || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      vld_r        <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
      out_tvalid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: clamp negatives, apply exposure, form luminance.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cin[i] = in_tdata[i*IN_W + IN_W - 1] ? '0 : in_tdata[i*IN_W +: CH_W];
    end
    wsel[0] = wr_r;
    wsel[1] = wg_r;
    wsel[2] = wb_r;
    wsum = 42'(wp_r[0]) + 42'(wp_r[1]) + 42'(wp_r[2]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        gp_r[i]  <= 40'(cin[i]) * 40'(gain_r);
        ch2_r[i] <= (|gp_r[i][39:GAIN_FRAC+CH_W]) ? CH_MAX
                                                   : gp_r[i][GAIN_FRAC +: CH_W];
        wp_r[i]  <= 40'(wsel[i]) * 40'(ch2_r[i]);
        ch3_r[i] <= ch2_r[i];
        ch4_r[i] <= ch3_r[i];
      end
      lum4_r <= (|wsum[41:40]) ? CH_MAX : wsum[39:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Curve units: one for luminance and one per channel, all in lockstep.
  // ---------------------------------------------------------------------------
  hpt_curve u_curve_lum (
    .clk (clk),
    .ce  (ce),
    .cd  (cd_r),
    .x   (lum4_r),
    .y   (mlum)
  );

  for (genvar g = 0; g < 3; g++) begin : g_chan
    hpt_curve u_curve_ch (
      .clk (clk),
      .ce  (ce),
      .cd  (cd_r),
      .x   (ch4_r[g]),
      .y   (cv[g])
    );
  end

  // Gained channels and luminance wait alongside the curve units.
  always_ff @(posedge clk) begin
    if (ce) begin
      lumdl_r[0] <= lum4_r;
      for (int i = 0; i < 3; i++) begin
        chdl_r[0][i] <= ch4_r[i];
      end
      for (int k = 1; k < CURVE_LAT; k++) begin
        lumdl_r[k] <= lumdl_r[k-1];
        for (int i = 0; i < 3; i++) begin
          chdl_r[k][i] <= chdl_r[k-1][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Luminance-scaled channel: ch * curve(lum) / lum. The quotient never exceeds
  // ch, because the curve never raises its input. Luminance of one code or more
  // is above the 1e-6 threshold; zero luminance gives zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      lsh[k] = 48'(lden_r[k]) << (DIV_STEPS - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lden_r[0] <= lumdl_r[CURVE_LAT-1];
      lnz_r[0]  <= |lumdl_r[CURVE_LAT-1];
      for (int i = 0; i < 3; i++) begin
        lrem_r[0][i] <= 48'(chdl_r[CURVE_LAT-1][i]) * 48'(mlum);
        lq_r[0][i]   <= '0;
        cvd_r[0][i]  <= cv[i];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        lden_r[k+1] <= lden_r[k];
        lnz_r[k+1]  <= lnz_r[k];
        for (int i = 0; i < 3; i++) begin
          cvd_r[k+1][i] <= cvd_r[k][i];
          if (lrem_r[k][i] >= lsh[k]) begin
            lrem_r[k+1][i] <= lrem_r[k][i] - lsh[k];
            lq_r[k+1][i]   <= lq_r[k][i] | (CH_W'(1) << (DIV_STEPS - 1 - k));
          end else begin
            lrem_r[k+1][i] <= lrem_r[k][i];
            lq_r[k+1][i]   <= lq_r[k][i];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Saturation-preserve mix and the divide by one hundred.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ls[i] = lnz_r[DIV_STEPS] ? lq_r[DIV_STEPS][i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mix_r[i] <= 31'(cvd_r[DIV_STEPS][i]) * 31'(7'd100 - q_pct)
                  + 31'(ls[i]) * 31'(q_pct);
        rp_r[i]  <= 63'(mix_r[i]) * 63'(RECIP_100);
        out_tdata_r[i*CH_W +: CH_W] <= rp_r[i][RECIP_SH +: CH_W];
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `HPT_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0], "accepted transaction missing from stage one")
  `HPT_ASSERT_NEXT(a_stall_holds, !ce, $stable(vld_r), "valid bits moved during a stall")
  `HPT_ASSERT_NEXT(a_last_reaches_out, ce && vld_r[PIPE_DEPTH-1], out_tvalid, "last stage did not reach the output register")
  `HPT_ASSERT_NOW(a_pivot_floor, 1'b1, cd_r.p >= P_MIN, "effective pivot below its floor")

endmodule
